// ----- sv/rac_pkg.sv -----
package rac_pkg;

	localparam int unsigned CHAN_MAX   = 255;
	localparam int unsigned ROUND_HALF = 'h80;

	// Pixel data that rides along the pipeline beside the arithmetic
	typedef struct packed {
		logic [7:0] dst_red;
		logic [7:0] dst_green;
		logic [7:0] dst_blue;
		logic [7:0] dst_alpha;
		logic [7:0] src_red;
		logic [7:0] src_green;
		logic [7:0] src_blue;
		logic [7:0] out_alpha;
		logic       pass;
	} carry_t;

endpackage

// ----- sv/rac_if.sv -----
interface rac_pair_if;
	logic       valid;
	logic       ready;
	logic [7:0] dst_red;
	logic [7:0] dst_green;
	logic [7:0] dst_blue;
	logic [7:0] dst_alpha;
	logic [7:0] src_red;
	logic [7:0] src_green;
	logic [7:0] src_blue;
	logic [7:0] src_alpha;

	modport source (output valid, output dst_red, output dst_green, output dst_blue,
		output dst_alpha, output src_red, output src_green, output src_blue,
		output src_alpha, input ready);
	modport sink (input valid, input dst_red, input dst_green, input dst_blue,
		input dst_alpha, input src_red, input src_green, input src_blue,
		input src_alpha, output ready);
endinterface

interface rac_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;
	logic [7:0] out_alpha;

	modport source (output valid, output out_red, output out_green, output out_blue,
		output out_alpha, input ready);
	modport sink (input valid, input out_red, input out_green, input out_blue,
		input out_alpha, output ready);
endinterface

// ----- sv/rgba_alpha_composite_over.sv -----
// Source-over-destination compositing of RGBA8 pixel pairs. One pixel pair is
// taken every cycle while no output stall has backed up to the input. The
// restoring divider that forms the blend coefficient gives one quotient bit
// per pipeline stage, 8 + FRACTION_BITS stages, behind two setup stages and
// ahead of four mixing stages. Every stage holds its own valid bit, so a stall
// at the output backs up one stage at a time and empty stages keep filling.
// A zero source alpha passes the destination through.
module rgba_alpha_composite_over #(
	parameter int FRACTION_BITS = 7
) (
	input  logic            clk,
	input  logic            arst_n,
	rac_pair_if.sink        pixels,
	rac_pix_if.source       result
);

	localparam int QW   = 8 + FRACTION_BITS;   // quotient / coefficient width
	localparam int PW   = 8 + QW;              // channel product width
	localparam int TW   = PW + 1;              // mixed channel sum width
	localparam int DIV0 = 2;                   // first divider stage
	localparam int ST_C = DIV0 + QW;
	localparam int ST_M = ST_C + 1;
	localparam int ST_A = ST_M + 1;
	localparam int ST_O = ST_A + 1;
	localparam int NS   = ST_O + 1;

	localparam logic [QW-1:0] FULL = QW'(rac_pkg::CHAN_MAX) << FRACTION_BITS;
	localparam logic [TW-1:0] RND  = TW'(rac_pkg::ROUND_HALF) << FRACTION_BITS;

	typedef struct packed {
		rac_pkg::carry_t c;
		logic [15:0]     dvs;
		logic [15:0]     rem;
		logic [QW-1:0]   quo;
		logic [QW-1:0]   bits;
	} div_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} res_t;

	logic [NS-1:0] vld_s;
	logic [NS-1:0] en;

	// Stage k loads when it is empty or its content moves on
	assign en[NS-1] = !vld_s[NS-1] || result.ready;
	for (genvar k = 0; k < NS - 1; k++) begin : g_en
		assign en[k] = !vld_s[k] || en[k+1];
	end

	assign pixels.ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 0; k < NS; k++) begin
				if (en[k]) begin
					vld_s[k] <= (k == 0) ? pixels.valid : vld_s[k-1];
				end
			end
		end
	end

	// Stage 1: blend = da * (255 - sa), sa * 255
	rac_pkg::carry_t c_s1;
	logic [15:0]     blend_s1;
	logic [15:0]     sa255_s1;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			c_s1.dst_red   <= pixels.dst_red;
			c_s1.dst_green <= pixels.dst_green;
			c_s1.dst_blue  <= pixels.dst_blue;
			c_s1.dst_alpha <= pixels.dst_alpha;
			c_s1.src_red   <= pixels.src_red;
			c_s1.src_green <= pixels.src_green;
			c_s1.src_blue  <= pixels.src_blue;
			c_s1.out_alpha <= '0;
			c_s1.pass      <= (pixels.src_alpha == 8'd0);
			blend_s1       <= 16'(pixels.dst_alpha) *
				16'(8'(rac_pkg::CHAN_MAX) - pixels.src_alpha);
			sa255_s1       <= {pixels.src_alpha, 8'd0} - {8'd0, pixels.src_alpha};
		end
	end

	// Stage 2: outa255, output alpha, numerator high part sa * 255 * 255
	rac_pkg::carry_t c_s2;
	logic [15:0]     outa_s2;
	logic [23:0]     numhi_s2;
	logic [15:0]     outa;
	logic [16:0]     arnd;
	logic [17:0]     asum;
	rac_pkg::carry_t c_al;

	always_comb begin
		outa = sa255_s1 + blend_s1;
		arnd = {1'b0, outa} + 17'(rac_pkg::ROUND_HALF);
		asum = {1'b0, arnd} + {9'd0, arnd[16:8]};
		c_al           = c_s1;
		c_al.out_alpha = asum[15:8];
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			c_s2           <= c_al;
			outa_s2        <= outa;
			numhi_s2       <= {sa255_s1, 8'd0} - {8'd0, sa255_s1};
		end
	end

	// Restoring divider, one quotient bit per stage. The quotient is known to
	// stay below 2^QW, so the upper numerator bits start as the remainder.
	div_t dv_init;
	div_t dv_s [QW];
	div_t dv_nx[QW];

	always_comb begin
		dv_init.c    = c_s2;
		dv_init.dvs  = outa_s2;
		dv_init.rem  = numhi_s2[23:8];
		dv_init.quo  = '0;
		dv_init.bits = {numhi_s2[7:0], {FRACTION_BITS{1'b0}}};
	end

	for (genvar k = 0; k < QW; k++) begin : g_div
		div_t        prev;
		logic [16:0] r2;
		logic [16:0] diff;
		logic        ge;

		if (k == 0) begin : g_first
			assign prev = dv_init;
		end else begin : g_next
			assign prev = dv_s[k-1];
		end

		always_comb begin
			r2              = {prev.rem, prev.bits[QW-1]};
			diff            = r2 - {1'b0, prev.dvs};
			ge              = (r2 >= {1'b0, prev.dvs});
			dv_nx[k]        = prev;
			dv_nx[k].rem    = ge ? diff[15:0] : r2[15:0];
			dv_nx[k].quo    = {prev.quo[QW-2:0], ge};
			dv_nx[k].bits   = prev.bits << 1;
		end

		always_ff @(posedge clk) begin
			if (en[DIV0+k]) begin
				dv_s[k] <= dv_nx[k];
			end
		end
	end

	// Coefficient stage
	rac_pkg::carry_t c_sc;
	logic [QW-1:0]   c1_sc;
	logic [QW-1:0]   c2_sc;
	logic [QW-1:0]   c1;

	assign c1 = (dv_s[QW-1].quo > FULL) ? FULL : dv_s[QW-1].quo;

	always_ff @(posedge clk) begin
		if (en[ST_C]) begin
			c_sc  <= dv_s[QW-1].c;
			c1_sc <= c1;
			c2_sc <= FULL - c1;
		end
	end

	// Multiply, sum with rounding, divide by 255 and scale down, or pass the destination through
	logic [7:0]      s_ch[3];
	logic [7:0]      d_ch[3];
	rac_pkg::carry_t c_sm;
	logic [PW-1:0]   ps_sm[3];
	logic [PW-1:0]   pd_sm[3];
	rac_pkg::carry_t c_sa;
	logic [TW-1:0]   t_sa[3];
	logic [TW-1:0]   dsum[3];
	res_t            o_so;

	always_comb begin
		s_ch[0] = c_sc.src_red;
		s_ch[1] = c_sc.src_green;
		s_ch[2] = c_sc.src_blue;
		d_ch[0] = c_sc.dst_red;
		d_ch[1] = c_sc.dst_green;
		d_ch[2] = c_sc.dst_blue;
		for (int i = 0; i < 3; i++) begin
			dsum[i] = t_sa[i] + (t_sa[i] >> 8);
		end
	end

	always_ff @(posedge clk) begin
		if (en[ST_M]) begin
			c_sm <= c_sc;
			for (int i = 0; i < 3; i++) begin
				ps_sm[i] <= PW'(s_ch[i]) * PW'(c1_sc);
				pd_sm[i] <= PW'(d_ch[i]) * PW'(c2_sc);
			end
		end
		if (en[ST_A]) begin
			c_sa <= c_sm;
			for (int i = 0; i < 3; i++) begin
				t_sa[i] <= {1'b0, ps_sm[i]} + {1'b0, pd_sm[i]} + RND;
			end
		end
		if (en[ST_O]) begin
			if (c_sa.pass) begin
				o_so.red   <= c_sa.dst_red;
				o_so.green <= c_sa.dst_green;
				o_so.blue  <= c_sa.dst_blue;
				o_so.alpha <= c_sa.dst_alpha;
			end else begin
				o_so.red   <= dsum[0][15+FRACTION_BITS:8+FRACTION_BITS];
				o_so.green <= dsum[1][15+FRACTION_BITS:8+FRACTION_BITS];
				o_so.blue  <= dsum[2][15+FRACTION_BITS:8+FRACTION_BITS];
				o_so.alpha <= c_sa.out_alpha;
			end
		end
	end

	assign result.valid     = vld_s[NS-1];
	assign result.out_red   = o_so.red;
	assign result.out_green = o_so.green;
	assign result.out_blue  = o_so.blue;
	assign result.out_alpha = o_so.alpha;

endmodule

// ----- dv/rac_checker.sv -----
`timescale 1ns / 100ps

module rac_checker #(
	parameter int FRACTION_BITS = 7
) (
	input  logic        clk,
	input  logic        arst_n,
	rac_pair_if         pairs,
	rac_pix_if          result,
	output int unsigned fail_count,
	output int unsigned outstanding,
	output int unsigned checked_count
);

	typedef struct packed {
		logic [7:0] dst_red;
		logic [7:0] dst_green;
		logic [7:0] dst_blue;
		logic [7:0] dst_alpha;
		logic [7:0] src_red;
		logic [7:0] src_green;
		logic [7:0] src_blue;
		logic [7:0] src_alpha;
	} pair_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} pixel_t;

	pixel_t      expected_pixels [$];
	int unsigned fails;
	int unsigned checks;

	// (v + v/256) / 256, close enough to v/255 for the ranges seen here
	function automatic logic [31:0] div255(input logic [31:0] v);
		return (v + (v >> 8)) >> 8;
	endfunction

	function automatic logic [7:0] blend_channel(input logic [7:0] s, input logic [7:0] d,
			input logic [31:0] c1, input logic [31:0] c2);
		logic [31:0] t;
		t = 32'(s) * c1 + 32'(d) * c2;
		return 8'(div255(t + (rac_pkg::ROUND_HALF << FRACTION_BITS)) >> FRACTION_BITS);
	endfunction

	function automatic pixel_t compose_over(input pair_t p);
		pixel_t      px;
		logic [31:0] blend;
		logic [31:0] outa;
		logic [31:0] full;
		logic [31:0] c1;
		logic [31:0] c2;
		logic [63:0] num;
		if (p.src_alpha == 8'd0) begin
			px.red   = p.dst_red;
			px.green = p.dst_green;
			px.blue  = p.dst_blue;
			px.alpha = p.dst_alpha;
			return px;
		end
		blend = 32'(p.dst_alpha) * (rac_pkg::CHAN_MAX - 32'(p.src_alpha));
		outa  = 32'(p.src_alpha) * rac_pkg::CHAN_MAX + blend;
		num   = (64'(p.src_alpha) * 64'(rac_pkg::CHAN_MAX) * 64'(rac_pkg::CHAN_MAX))
			<< FRACTION_BITS;
		full  = rac_pkg::CHAN_MAX << FRACTION_BITS;
		c1    = 32'(num / 64'(outa));
		if (c1 > full)
			c1 = full;
		c2 = full - c1;
		px.red   = blend_channel(p.src_red, p.dst_red, c1, c2);
		px.green = blend_channel(p.src_green, p.dst_green, c1, c2);
		px.blue  = blend_channel(p.src_blue, p.dst_blue, c1, c2);
		px.alpha = 8'(div255(outa + rac_pkg::ROUND_HALF));
		return px;
	endfunction

	task automatic compare_field(input string name, input logic [7:0] want,
			input logic [7:0] got, inout bit bad);
		if (got !== want) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			bad = 1'b1;
		end
	endtask

	initial begin
		fails  = 0;
		checks = 0;
	end

	always @(posedge clk) begin
		pixel_t want;
		bit     bad;
		if (!arst_n) begin
			fail_count    <= 0;
			outstanding   <= 0;
			checked_count <= 0;
		end else begin
			if (pairs.valid && pairs.ready)
				expected_pixels.push_back(compose_over({pairs.dst_red, pairs.dst_green,
					pairs.dst_blue, pairs.dst_alpha, pairs.src_red, pairs.src_green,
					pairs.src_blue, pairs.src_alpha}));
			if (result.valid && result.ready) begin
				if (expected_pixels.size() == 0) begin
					$display("%0t: unexpected pixel r=%0d g=%0d b=%0d a=%0d", $time,
						result.out_red, result.out_green, result.out_blue, result.out_alpha);
					fails++;
				end else begin
					want = expected_pixels.pop_front();
					bad  = 1'b0;
					compare_field("out_red", want.red, result.out_red, bad);
					compare_field("out_green", want.green, result.out_green, bad);
					compare_field("out_blue", want.blue, result.out_blue, bad);
					compare_field("out_alpha", want.alpha, result.out_alpha, bad);
					if (bad)
						fails++;
				end
				checks++;
			end
			fail_count    <= fails;
			outstanding   <= unsigned'(expected_pixels.size());
			checked_count <= checks;
		end
	end

endmodule

// ----- dv/rgba_alpha_composite_over_test.sv -----
`timescale 1ns / 100ps

module rgba_alpha_composite_over_test;

	localparam int FRACTION_BITS = 7;
	localparam int STALL_LIMIT   = 2000;
	localparam int DRAIN_CYCLES  = 40;

	typedef struct packed {
		logic [7:0] dst_red;
		logic [7:0] dst_green;
		logic [7:0] dst_blue;
		logic [7:0] dst_alpha;
		logic [7:0] src_red;
		logic [7:0] src_green;
		logic [7:0] src_blue;
		logic [7:0] src_alpha;
	} pair_t;

	logic        clk = 1'b0;
	logic        arst_n;
	bit          no_idle;
	int unsigned fail_count;
	int unsigned outstanding;
	int unsigned checked_count;
	int unsigned sent;
	int unsigned sent_clear;
	int unsigned sent_opaque;
	int unsigned idle_cycles;

	rac_pair_if pair_bus ();
	rac_pix_if  pix_bus ();

	rgba_alpha_composite_over #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pixels (pair_bus.sink),
		.result (pix_bus.source)
	);

	rac_checker #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.pairs         (pair_bus),
		.result        (pix_bus),
		.fail_count    (fail_count),
		.outstanding   (outstanding),
		.checked_count (checked_count)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// mostly back to back, sometimes a short gap, rarely a long hole
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic pair_t random_pair();
		pair_t       p;
		int unsigned r;
		p = {$urandom, $urandom};
		r = $urandom_range(0, 99);
		if (r < 15)
			p.src_alpha = 8'd0;
		else if (r < 30)
			p.src_alpha = 8'd255;
		else if (r < 40)
			p.src_alpha = 8'd1;
		r = $urandom_range(0, 99);
		if (r < 10)
			p.dst_alpha = 8'd0;
		else if (r < 20)
			p.dst_alpha = 8'd255;
		return p;
	endfunction

	task automatic send_pair(input pair_t p);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			pair_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pair_bus.valid     <= 1'b1;
		pair_bus.dst_red   <= p.dst_red;
		pair_bus.dst_green <= p.dst_green;
		pair_bus.dst_blue  <= p.dst_blue;
		pair_bus.dst_alpha <= p.dst_alpha;
		pair_bus.src_red   <= p.src_red;
		pair_bus.src_green <= p.src_green;
		pair_bus.src_blue  <= p.src_blue;
		pair_bus.src_alpha <= p.src_alpha;
		@(posedge clk);
		while (!pair_bus.ready)
			@(posedge clk);
		sent++;
		if (p.src_alpha == 8'd0)
			sent_clear++;
		if (p.src_alpha == 8'd255)
			sent_opaque++;
	endtask

	// outstanding is registered in the checker and lags the queue it counts
	task automatic drain_results();
		pair_bus.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	initial begin
		pair_t directed [$];
		arst_n             <= 1'b0;
		no_idle            = 1'b0;
		sent               = 0;
		sent_clear         = 0;
		sent_opaque        = 0;
		pair_bus.valid     <= 1'b0;
		pair_bus.dst_red   <= 8'd0;
		pair_bus.dst_green <= 8'd0;
		pair_bus.dst_blue  <= 8'd0;
		pair_bus.dst_alpha <= 8'd0;
		pair_bus.src_red   <= 8'd0;
		pair_bus.src_green <= 8'd0;
		pair_bus.src_blue  <= 8'd0;
		pair_bus.src_alpha <= 8'd0;

		// transparent source: destination must come through untouched
		directed.push_back({8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0});
		directed.push_back({8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0});
		directed.push_back({8'h55, 8'haa, 8'h0f, 8'hf0, 8'haa, 8'h55, 8'hf0, 8'd0});
		// opaque source: source colour reproduced exactly
		directed.push_back({8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255});
		directed.push_back({8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd255});
		directed.push_back({8'h12, 8'h34, 8'h56, 8'h78, 8'h9a, 8'hbc, 8'hde, 8'd255});
		// faintest source over empty and over opaque destination
		directed.push_back({8'd255, 8'd0, 8'd128, 8'd0, 8'd0, 8'd255, 8'd127, 8'd1});
		directed.push_back({8'd255, 8'd0, 8'd128, 8'd255, 8'd0, 8'd255, 8'd127, 8'd1});
		directed.push_back({8'd0, 8'd255, 8'd1, 8'd255, 8'd255, 8'd0, 8'd254, 8'd1});
		directed.push_back({8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 8'd128});
		directed.push_back({8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd128});
		directed.push_back({8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd127});
		directed.push_back({8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd254});
		directed.push_back({8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd254});
		directed.push_back({8'haa, 8'h55, 8'haa, 8'h55, 8'h55, 8'haa, 8'h55, 8'haa});
		directed.push_back({8'h55, 8'haa, 8'h55, 8'haa, 8'haa, 8'h55, 8'haa, 8'h55});
		directed.push_back({8'd1, 8'd2, 8'd4, 8'd8, 8'd16, 8'd32, 8'd64, 8'd128});
		directed.push_back({8'd128, 8'd64, 8'd32, 8'd16, 8'd8, 8'd4, 8'd2, 8'd1});

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed[i])
			send_pair(directed[i]);
		repeat (150)
			send_pair(random_pair());
		drain_results();
		no_idle = 1'b1;
		repeat (100)
			send_pair(random_pair());
		no_idle = 1'b0;
		repeat (200)
			send_pair(random_pair());
		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Composited %0d pixel pairs (%0d transparent, %0d opaque source), %0d checked,",
			sent, sent_clear, sent_opaque, checked_count);
		$display("with random gaps, stalls, a full drain mid-run and a back-to-back burst.");
		if (outstanding != 0)
			$display("%0t: %0d composite pixels never arrived", $time, outstanding);
		if (fail_count == 0 && outstanding == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// output stall pattern: random runs of ready, random holes between them
	initial begin
		int unsigned stall;
		pix_bus.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			stall = pick_gap();
			if (stall != 0) begin
				pix_bus.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pix_bus.ready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end
	end

	initial begin
		idle_cycles = 0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((pair_bus.valid && pair_bus.ready) || (pix_bus.valid && pix_bus.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
